### hw/rtl/mif_pkg.sv
// Shared types, constants and microcode for the mixer IIR filter.
// Used by mif_sequencer, mif_mac and mixer_iir_filter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mif_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int X_W         = 2 * SAMPLE_BITS + 1;
  localparam int COEF_W      = 24;
  localparam int Y_W         = 24;
  localparam int HIST_DEPTH  = 4;
  localparam int MUL_A_W     = (COEF_W > DIFF_W) ? COEF_W : DIFF_W;
  localparam int MUL_B_W     = (X_W > Y_W) ? X_W : Y_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = COEF_W;
  localparam int STEP_W      = 4;

  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] DAC_MAX = '1;

  localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET = 12'd620;
  localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd1049;
  localparam logic signed [COEF_W-1:0] B2_RESET = -24'sd2097;
  localparam logic signed [COEF_W-1:0] B4_RESET = 24'sd1049;
  localparam logic signed [COEF_W-1:0] A1_RESET = 24'sd3319792;
  localparam logic signed [COEF_W-1:0] A2_RESET = -24'sd4632609;
  localparam logic signed [COEF_W-1:0] A3_RESET = 24'sd3175088;
  localparam logic signed [COEF_W-1:0] A4_RESET = -24'sd959447;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_first;
    logic [SAMPLE_BITS-1:0] sample_second;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] dac_code;
    logic                   clipped;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET, REG_B0, REG_B2, REG_B4, REG_A1, REG_A2, REG_A3, REG_A4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MA_DIFF, MA_B0, MA_B2, MA_B4, MA_A1, MA_A2, MA_A3, MA_A4
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_DIFF, MB_X0, MB_PH1, MB_PH3, MB_OH0, MB_OH1, MB_OH2, MB_OH3
  } mul_b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    WAIT_NONE, WAIT_IN, WAIT_OUT
  } wait_t;

  typedef enum logic [STEP_W-1:0] {
    ST_IDLE, ST_X0, ST_T_B2, ST_T_B4, ST_T_B0,
    ST_T_A1, ST_T_A2, ST_T_A3, ST_T_A4, ST_FINISH
  } step_t;

  typedef struct packed {
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    acc_op_t    acc_op;
    logic       x0_load;
    logic       finish;
    wait_t      wait_on;
    step_t      next_step;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } seq_cond_t;

  function automatic int acc_width(input int frac_bits);
    int raw;
    raw = PROD_W - frac_bits + 3;
    return (raw > Y_W + 1) ? raw : Y_W + 1;
  endfunction

  function automatic ctrl_word_t uword(input mul_a_sel_t ma, input mul_b_sel_t mb,
                                       input acc_op_t op, input logic x0l,
                                       input logic fin, input wait_t wt,
                                       input step_t nxt);
    ctrl_word_t w;
    w.mul_a     = ma;
    w.mul_b     = mb;
    w.acc_op    = op;
    w.x0_load   = x0l;
    w.finish    = fin;
    w.wait_on   = wt;
    w.next_step = nxt;
    return w;
  endfunction

  // Product issued in one step is accumulated in the next.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    unique case (step)
      ST_IDLE:   w = uword(MA_DIFF, MB_DIFF, ACC_HOLD, 1'b0, 1'b0, WAIT_IN,   ST_X0);
      ST_X0:     w = uword(MA_B2,   MB_PH1,  ACC_HOLD, 1'b1, 1'b0, WAIT_NONE, ST_T_B2);
      ST_T_B2:   w = uword(MA_B4,   MB_PH3,  ACC_LOAD, 1'b0, 1'b0, WAIT_NONE, ST_T_B4);
      ST_T_B4:   w = uword(MA_B0,   MB_X0,   ACC_ADD,  1'b0, 1'b0, WAIT_NONE, ST_T_B0);
      ST_T_B0:   w = uword(MA_A1,   MB_OH0,  ACC_ADD,  1'b0, 1'b0, WAIT_NONE, ST_T_A1);
      ST_T_A1:   w = uword(MA_A2,   MB_OH1,  ACC_ADD,  1'b0, 1'b0, WAIT_NONE, ST_T_A2);
      ST_T_A2:   w = uword(MA_A3,   MB_OH2,  ACC_ADD,  1'b0, 1'b0, WAIT_NONE, ST_T_A3);
      ST_T_A3:   w = uword(MA_A4,   MB_OH3,  ACC_ADD,  1'b0, 1'b0, WAIT_NONE, ST_T_A4);
      ST_T_A4:   w = uword(MA_DIFF, MB_DIFF, ACC_ADD,  1'b0, 1'b0, WAIT_NONE, ST_FINISH);
      ST_FINISH: w = uword(MA_DIFF, MB_DIFF, ACC_HOLD, 1'b0, 1'b1, WAIT_OUT,  ST_IDLE);
      default:   w = uword(MA_DIFF, MB_DIFF, ACC_HOLD, 1'b0, 1'b0, WAIT_NONE, ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mif_sequencer.sv
// Step counter and microcode fetch for the mixer IIR filter.
// Depends on mif_pkg for the control word, step codes and ROM.
`timescale 1ns / 1ps
`default_nettype none

module mif_sequencer import mif_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire seq_cond_t  cond,
  output ctrl_word_t      ctrl
);

  step_t step;
  step_t step_next;
  logic  advance;

  always_comb begin
    ctrl = ucode_rom(step);
  end

  always_comb begin
    unique case (ctrl.wait_on)
      WAIT_NONE: advance = 1'b1;
      WAIT_IN:   advance = cond.in_fire;
      WAIT_OUT:  advance = cond.out_free;
      default:   advance = 1'b0;
    endcase
    step_next = advance ? ctrl.next_step : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mif_mac.sv
// Shared multiplier with registered product, floor shift and accumulator.
// Depends on mif_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module mif_mac import mif_pkg::*; #(
  parameter int COEF_FRAC_BITS = 20,
  parameter int ACC_W          = 32
) (
  input  wire logic                       clk,
  input  wire acc_op_t                    acc_op,
  input  wire logic signed [MUL_A_W-1:0]  mul_a,
  input  wire logic signed [MUL_B_W-1:0]  mul_b,
  output logic signed [PROD_W-1:0]        prod,
  output logic signed [ACC_W-1:0]         acc
);

  localparam int TERM_W = PROD_W - COEF_FRAC_BITS;

  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [ACC_W-1:0]  acc_next;

  // drop fraction bits: arithmetic shift floors toward minus infinity
  assign term     = prod[PROD_W-1:COEF_FRAC_BITS];
  assign term_ext = ACC_W'(term);

  always_comb begin
    unique case (acc_op)
      ACC_LOAD: acc_next = term_ext;
      ACC_ADD:  acc_next = acc + term_ext;
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    acc  <= acc_next;
  end

endmodule

`default_nettype wire

### hw/rtl/mixer_iir_filter.sv
// Top level: mixer, fourth-order direct-form-I IIR filter and DAC clamp.
// Depends on mif_pkg, mif_sequencer and mif_mac.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    in_word_t  (two raw samples)
//   out      output     out_valid / out_ready  out_word_t (DAC code, clip flag)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each word is worked through the steps X0, T_B2, T_B4, T_B0, T_A1, T_A2,
// T_A3, T_A4 and FINISH, in that order, on the single shared multiplier
// that forms the mixer product and all seven taps. A new word is taken
// only after the previous result is registered, so words do not overlap.
// rst clears the step counter, configuration registers to defaults and filter history.
// A stalled output holds the sequencer in its final step; cfg never stalls.
`timescale 1ns / 1ps
`default_nettype none

module mixer_iir_filter import mif_pkg::*; #(
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_word_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_word_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ACC_W = acc_width(COEF_FRAC_BITS);

  logic [SAMPLE_BITS-1:0]   sample_offset;
  logic signed [COEF_W-1:0] coef_b0, coef_b2, coef_b4;
  logic signed [COEF_W-1:0] coef_a1, coef_a2, coef_a3, coef_a4;

  logic signed [X_W-1:0] x0;
  logic signed [X_W-1:0] prod_hist [HIST_DEPTH];
  logic signed [Y_W-1:0] out_hist  [HIST_DEPTH];

  ctrl_word_t ctrl;
  seq_cond_t  cond;
  logic       in_fire;
  logic       out_free;
  logic       fin_fire;

  logic signed [DIFF_W-1:0]  diff_first, diff_second;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic                   acc_fits;
  logic signed [Y_W-1:0]  y_sat;
  logic signed [Y_W:0]    dac_sum;
  logic [SAMPLE_BITS-1:0] dac_code;
  logic                   dac_clamp;

  assign in_ready  = (ctrl.wait_on == WAIT_IN);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign fin_fire  = ctrl.finish && out_free;
  assign cfg_ready = 1'b1;

  assign cond.in_fire  = in_fire;
  assign cond.out_free = out_free;

  mif_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_offset <= OFFSET_RESET;
      coef_b0       <= B0_RESET;
      coef_b2       <= B2_RESET;
      coef_b4       <= B4_RESET;
      coef_a1       <= A1_RESET;
      coef_a2       <= A2_RESET;
      coef_a3       <= A3_RESET;
      coef_a4       <= A4_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET: sample_offset <= cfg_data[SAMPLE_BITS-1:0];
        REG_B0:     coef_b0 <= cfg_data[COEF_W-1:0];
        REG_B2:     coef_b2 <= cfg_data[COEF_W-1:0];
        REG_B4:     coef_b4 <= cfg_data[COEF_W-1:0];
        REG_A1:     coef_a1 <= cfg_data[COEF_W-1:0];
        REG_A2:     coef_a2 <= cfg_data[COEF_W-1:0];
        REG_A3:     coef_a3 <= cfg_data[COEF_W-1:0];
        REG_A4:     coef_a4 <= cfg_data[COEF_W-1:0];
        default:    sample_offset <= sample_offset;
      endcase
    end
  end

  // remove offset from both samples
  assign diff_first  = $signed({1'b0, in_data.sample_first})  - $signed({1'b0, sample_offset});
  assign diff_second = $signed({1'b0, in_data.sample_second}) - $signed({1'b0, sample_offset});

  always_comb begin
    unique case (ctrl.mul_a)
      MA_DIFF: mul_a = MUL_A_W'(diff_first);
      MA_B0:   mul_a = MUL_A_W'(coef_b0);
      MA_B2:   mul_a = MUL_A_W'(coef_b2);
      MA_B4:   mul_a = MUL_A_W'(coef_b4);
      MA_A1:   mul_a = MUL_A_W'(coef_a1);
      MA_A2:   mul_a = MUL_A_W'(coef_a2);
      MA_A3:   mul_a = MUL_A_W'(coef_a3);
      MA_A4:   mul_a = MUL_A_W'(coef_a4);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.mul_b)
      MB_DIFF: mul_b = MUL_B_W'(diff_second);
      MB_X0:   mul_b = MUL_B_W'(x0);
      MB_PH1:  mul_b = MUL_B_W'(prod_hist[1]);
      MB_PH3:  mul_b = MUL_B_W'(prod_hist[3]);
      MB_OH0:  mul_b = MUL_B_W'(out_hist[0]);
      MB_OH1:  mul_b = MUL_B_W'(out_hist[1]);
      MB_OH2:  mul_b = MUL_B_W'(out_hist[2]);
      MB_OH3:  mul_b = MUL_B_W'(out_hist[3]);
      default: mul_b = '0;
    endcase
  end

  mif_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_W          (ACC_W)
  ) u_mac (
    .clk    (clk),
    .acc_op (ctrl.acc_op),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod   (prod),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (ctrl.x0_load) begin
      x0 <= prod[X_W-1:0];
    end
  end

  // saturate filter sum to the output history width
  assign acc_fits = (acc[ACC_W-1:Y_W-1] == '0) || (acc[ACC_W-1:Y_W-1] == '1);
  assign y_sat    = acc_fits ? acc[Y_W-1:0] : (acc[ACC_W-1] ? Y_MIN : Y_MAX);

  // add offset back and clamp to DAC range
  assign dac_sum = (Y_W+1)'(y_sat) + $signed({{(Y_W+1-SAMPLE_BITS){1'b0}}, sample_offset});

  always_comb begin
    if (dac_sum[Y_W]) begin
      dac_code  = '0;
      dac_clamp = 1'b1;
    end else if (dac_sum[Y_W-1:SAMPLE_BITS] != '0) begin
      dac_code  = DAC_MAX;
      dac_clamp = 1'b1;
    end else begin
      dac_code  = dac_sum[SAMPLE_BITS-1:0];
      dac_clamp = 1'b0;
    end
  end

  // advance filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        prod_hist[i] <= '0;
        out_hist[i]  <= '0;
      end
    end else if (fin_fire) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        prod_hist[i] <= prod_hist[i-1];
        out_hist[i]  <= out_hist[i-1];
      end
      prod_hist[0] <= x0;
      out_hist[0]  <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data.dac_code <= dac_code;
      out_data.clipped  <= !acc_fits || dac_clamp;
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("sequencer stayed ready after taking a word");

  a_result_registered: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> out_valid)
    else $error("finished word not presented on output");

  a_idle_not_finish: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && ctrl.finish))
    else $error("input accept and finish in the same step");

endmodule

`default_nettype wire
